/* design/lasu_pkg.sv */
package lasu_pkg;

   localparam int FRAC_BITS = 20;
   localparam int LOG_FRAC  = 30;
   localparam int MANT_W    = 32;
   localparam int INT_W     = 7;
   localparam int LOG_W     = INT_W + LOG_FRAC;
   localparam int MAG_W     = 36;
   localparam int LN2_W     = 28;
   localparam int LO_W      = MAG_W / 2;
   localparam int HI_W      = MAG_W - LO_W;
   localparam int PROD_W    = MAG_W + LN2_W;
   localparam int NAT_SH    = LOG_FRAC + LN2_W - FRAC_BITS;
   localparam int QB        = 34;
   localparam int NUM_W     = MAG_W + FRAC_BITS + 1;
   localparam int DSH_W     = MAG_W + QB - 1;
   localparam int OVF_SH    = QB - FRAC_BITS - 1;

   localparam logic [LN2_W-1:0] LN2_Q28 = 28'hB17217F;

   localparam logic signed [31:0] RES_MAX = 32'sh7FFFFFFF;
   localparam logic signed [31:0] RES_MIN = 32'sh80000000;
   localparam logic signed [31:0] NEG_RES =
      (FRAC_BITS > 21) ? RES_MIN : 32'(-64'sd1000 * (64'sd1 <<< FRAC_BITS));

   typedef struct packed {
      logic valid;
      logic vneg;
      logic bneg;
   } lasu_ctl_type;

   typedef struct packed {
      lasu_ctl_type             ctl;
      logic signed [INT_W-1:0]  pv;
      logic signed [INT_W-1:0]  pb;
      logic [MANT_W-1:0]        mv;
      logic [MANT_W-1:0]        mb;
      logic [LOG_FRAC-1:0]      fv;
      logic [LOG_FRAC-1:0]      fb;
   } lasu_log_type;

   typedef struct packed {
      lasu_ctl_type             ctl;
      logic                     lv_neg;
      logic                     lb_neg;
      logic [MAG_W-1:0]         nm;
      logic [MAG_W-1:0]         dm;
      logic [LO_W+LN2_W-1:0]    plo;
      logic [HI_W+LN2_W-1:0]    phi;
   } lasu_mid_type;

   typedef struct packed {
      lasu_ctl_type             ctl;
      logic                     neg;
      logic                     lv_pos;
      logic                     lv_neg;
      logic                     dzero;
      logic                     ovf;
      logic signed [31:0]       nat;
      logic [NUM_W-1:0]         rem;
      logic [DSH_W-1:0]         dsh;
      logic [QB-1:0]            q;
   } lasu_div_type;

endpackage

/* design/lasu_log_cell.sv */
module lasu_log_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  lasu_pkg::lasu_log_type prev,
   output lasu_pkg::lasu_log_type next
);
   import lasu_pkg::*;

   lasu_log_type          out_ff;
   lasu_log_type          out_in;
   logic [2*MANT_W-1:0]   sqv;
   logic [2*MANT_W-1:0]   sqb;
   logic [MANT_W:0]       tv;
   logic [MANT_W:0]       tb;

   always_comb begin
      sqv = {{MANT_W{1'b0}}, prev.mv} * {{MANT_W{1'b0}}, prev.mv};
      sqb = {{MANT_W{1'b0}}, prev.mb} * {{MANT_W{1'b0}}, prev.mb};
      tv  = sqv[2*MANT_W-1:MANT_W-1];
      tb  = sqb[2*MANT_W-1:MANT_W-1];
      out_in    = prev;
      // halve on reaching 2.0 and emit a one
      out_in.mv = tv[MANT_W] ? tv[MANT_W:1] : tv[MANT_W-1:0];
      out_in.mb = tb[MANT_W] ? tb[MANT_W:1] : tb[MANT_W-1:0];
      out_in.fv = {prev.fv[LOG_FRAC-2:0], tv[MANT_W]};
      out_in.fb = {prev.fb[LOG_FRAC-2:0], tb[MANT_W]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.ctl.valid <= 1'b0;
      end else if (adv) begin
         out_ff <= out_in;
      end
   end

   assign next = out_ff;

endmodule

/* design/lasu_div_cell.sv */
module lasu_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  lasu_pkg::lasu_div_type prev,
   output lasu_pkg::lasu_div_type next
);
   import lasu_pkg::*;

   lasu_div_type out_ff;
   lasu_div_type out_in;
   logic         ge;

   always_comb begin
      ge      = {{(DSH_W-NUM_W){1'b0}}, prev.rem} >= prev.dsh;
      out_in  = prev;
      out_in.rem = ge ? prev.rem - prev.dsh[NUM_W-1:0] : prev.rem;
      out_in.dsh = prev.dsh >> 1;
      out_in.q   = {prev.q[QB-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.ctl.valid <= 1'b0;
      end else if (adv) begin
         out_ff <= out_in;
      end
   end

   assign next = out_ff;

endmodule

/* design/log_any_base_sample_unit.sv */
// Pipeline from an input transfer to its result on rsp_valid:
// 1 normalize, 30 squaring cells, 2 log/scale stages, 34 divider cells, 1 output.
// One item per cycle when not stalled; every cell then hands its item on each cycle.
// The whole chain holds while a result waits with rsp_stall high.
// Reset (synchronous, active high) clears all valid bits; the chain is empty.
module log_any_base_sample_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_sample_value,
   input  logic signed [31:0] req_log_base,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_log_result
);
   import lasu_pkg::*;

   logic               adv;
   lasu_log_type       norm_ff;
   lasu_log_type       norm_in;
   lasu_log_type       lchain [0:LOG_FRAC];
   lasu_mid_type       mid_ff;
   lasu_mid_type       mid_in;
   lasu_div_type       dstart_ff;
   lasu_div_type       dstart_in;
   lasu_div_type       dchain [0:QB];
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_log_result_ff;
   logic signed [31:0] rsp_log_result_in;

   logic [30:0]        vu;
   logic [30:0]        bu;
   logic [4:0]         pv;
   logic [4:0]         pb;
   logic signed [LOG_W-1:0] lv;
   logic signed [LOG_W-1:0] lb;
   logic [LOG_W-1:0]   lv_abs;
   logic [LOG_W-1:0]   lb_abs;
   logic [PROD_W-1:0]  prod;
   logic [PROD_W-1:0]  prod_rnd;
   logic [32:0]        nat_mag;
   logic signed [33:0] nat_s;
   lasu_div_type       dend;
   logic [QB:0]        q_inc;
   logic [QB-1:0]      q_rnd;
   logic signed [31:0] quo;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   // normalize both operands to Q1.31
   always_comb begin
      vu = req_sample_value[30:0];
      bu = req_log_base[30:0];
      pv = '0;
      pb = '0;
      for (int i = 0; i < 31; i++) begin
         if (vu[i]) pv = 5'(i);
         if (bu[i]) pb = 5'(i);
      end
      norm_in.ctl.valid = req_valid;
      norm_in.ctl.vneg  = req_sample_value <= 0;
      norm_in.ctl.bneg  = req_log_base <= 0;
      norm_in.pv = INT_W'(pv) - INT_W'(FRAC_BITS);
      norm_in.pb = INT_W'(pb) - INT_W'(FRAC_BITS);
      norm_in.mv = MANT_W'({1'b0, vu} << (5'd31 - pv));
      norm_in.mb = MANT_W'({1'b0, bu} << (5'd31 - pb));
      norm_in.fv = '0;
      norm_in.fb = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         norm_ff.ctl.valid <= 1'b0;
      end else if (adv) begin
         norm_ff <= norm_in;
      end
   end

   assign lchain[0] = norm_ff;

   for (genvar g = 0; g < LOG_FRAC; g++) begin : g_log
      lasu_log_cell u_cell (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .prev  (lchain[g]),
         .next  (lchain[g+1])
      );
   end

   // assemble log2 values, start ln scaling with split products
   always_comb begin
      lv     = {lchain[LOG_FRAC].pv, lchain[LOG_FRAC].fv};
      lb     = {lchain[LOG_FRAC].pb, lchain[LOG_FRAC].fb};
      lv_abs = lv[LOG_W-1] ? -lv : lv;
      lb_abs = lb[LOG_W-1] ? -lb : lb;
      mid_in.ctl    = lchain[LOG_FRAC].ctl;
      mid_in.lv_neg = lv[LOG_W-1];
      mid_in.lb_neg = lb[LOG_W-1];
      mid_in.nm     = lv_abs[MAG_W-1:0];
      mid_in.dm     = lb_abs[MAG_W-1:0];
      mid_in.plo    = {{HI_W{1'b0}}, lv_abs[LO_W-1:0]} * {{LO_W{1'b0}}, LN2_Q28};
      mid_in.phi    = {{HI_W{1'b0}}, lv_abs[MAG_W-1:LO_W]} * {{HI_W{1'b0}}, LN2_Q28};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff.ctl.valid <= 1'b0;
      end else if (adv) begin
         mid_ff <= mid_in;
      end
   end

   // finish ln, set up the divider
   always_comb begin
      prod     = {mid_ff.phi, {LO_W{1'b0}}} + PROD_W'(mid_ff.plo);
      prod_rnd = prod + (PROD_W'(1) << (NAT_SH - 1));
      nat_mag  = 33'(prod_rnd >> NAT_SH);
      nat_s    = mid_ff.lv_neg ? -{1'b0, nat_mag} : {1'b0, nat_mag};
      dstart_in.ctl    = mid_ff.ctl;
      dstart_in.neg    = mid_ff.lv_neg != mid_ff.lb_neg;
      dstart_in.lv_neg = mid_ff.lv_neg;
      dstart_in.lv_pos = !mid_ff.lv_neg && (mid_ff.nm != '0);
      dstart_in.dzero  = mid_ff.dm == '0;
      dstart_in.ovf    = {{QB{1'b0}}, mid_ff.nm} >= ({{QB{1'b0}}, mid_ff.dm} << OVF_SH);
      if (nat_s > 34'(RES_MAX)) begin
         dstart_in.nat = RES_MAX;
      end else if (nat_s < 34'(RES_MIN)) begin
         dstart_in.nat = RES_MIN;
      end else begin
         dstart_in.nat = nat_s[31:0];
      end
      dstart_in.rem = {mid_ff.nm, {(FRAC_BITS+1){1'b0}}};
      dstart_in.dsh = {mid_ff.dm, {(QB-1){1'b0}}};
      dstart_in.q   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dstart_ff.ctl.valid <= 1'b0;
      end else if (adv) begin
         dstart_ff <= dstart_in;
      end
   end

   assign dchain[0] = dstart_ff;

   for (genvar g = 0; g < QB; g++) begin : g_div
      lasu_div_cell u_cell (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .prev  (dchain[g]),
         .next  (dchain[g+1])
      );
   end

   // round, saturate, pick the case
   always_comb begin
      dend  = dchain[QB];
      q_inc = {1'b0, dend.q} + (QB+1)'(1);
      q_rnd = q_inc[QB:1];
      if (dend.neg) begin
         quo = (q_rnd > QB'(64'h80000000)) ? RES_MIN : -(q_rnd[31:0]);
      end else begin
         quo = (q_rnd > QB'(64'h7FFFFFFF)) ? RES_MAX : q_rnd[31:0];
      end
      priority if (dend.ctl.vneg) begin
         rsp_log_result_in = NEG_RES;
      end else if (dend.ctl.bneg) begin
         rsp_log_result_in = dend.nat;
      end else if (dend.dzero) begin
         rsp_log_result_in = dend.lv_pos ? RES_MAX : (dend.lv_neg ? RES_MIN : '0);
      end else if (dend.ovf) begin
         rsp_log_result_in = dend.neg ? RES_MIN : RES_MAX;
      end else begin
         rsp_log_result_in = quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff      <= dend.ctl.valid;
         rsp_log_result_ff <= rsp_log_result_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_log_result = rsp_log_result_ff;

endmodule

/* design/lasu_checker.sv */
module lasu_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_log_result
);

   // hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_log_result))
      else $error("stalled result changed");

   // input side stalls exactly when a result is blocked
   assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not track output stall");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // no result can appear right after reset, the chain is long
   assert property (@(posedge clock)
      $past(reset) && !reset |=> !rsp_valid)
      else $error("result appeared too early after reset");

endmodule

bind log_any_base_sample_unit lasu_checker u_lasu_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_log_result (rsp_log_result)
);
